FILE: rtl/fvn_pkg.sv
// Shared constants, types and arithmetic helpers for the fractal value noise unit.
// No dependencies; every other file takes its names from here by scoped reference.

package fvn_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int POS_W           = 19;
  localparam int SUM_W           = 17;
  localparam int CFG_W           = 3;
  localparam int SHIFT_LIMIT     = 4;
  localparam int DEF_MAX_OCTAVES = 6;
  localparam int AMP_DEPTH       = 8;
  localparam int AMP_W           = 17;
  localparam int AMP_SHIFT       = 16;

  localparam int HASH_MOD  = 289;
  localparam int HASH_MUL  = 34;
  localparam int VALUE_MOD = 41;
  localparam int RES_W     = $clog2(HASH_MOD);
  localparam int VM_W      = $clog2(VALUE_MOD);

  // floored mod 289 by reciprocal multiply, one correction step
  localparam int MOD_ARG_W = 24;
  localparam int MOD_SHIFT = 32;
  localparam int MOD_Q_W   = 2 * MOD_ARG_W - MOD_SHIFT;
  localparam logic [MOD_ARG_W-1:0] MOD_RECIP =
    MOD_ARG_W'((64'd1 << MOD_SHIFT) / HASH_MOD);

  // mod 41 of a residue below 289
  localparam int V41_SHIFT = 16;
  localparam int V41_W     = 11;
  localparam logic [V41_W-1:0] V41_RECIP =
    V41_W'(((1 << V41_SHIFT) + VALUE_MOD - 1) / VALUE_MOD);
  localparam int V41_P_W   = RES_W + V41_W;

  localparam int VAL_W = FRAC_BITS + 1;

  localparam int LANE_STAGES = 22;
  localparam int PIPE_STAGES = LANE_STAGES + 1;

  typedef logic [RES_W-1:0] res_t;
  typedef logic [VAL_W-1:0] val_t;
  typedef logic [FRAC_BITS-1:0] cv_tab_t [VALUE_MOD];

  typedef enum logic {
    REG_OCTAVE_COUNT = 1'b0,
    REG_BASE_SHIFT   = 1'b1
  } cfg_reg_e;

  localparam logic [AMP_W-1:0] AMP_Q16 [AMP_DEPTH] = '{
    17'd65536, 17'd24110, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60
  };

  function automatic cv_tab_t build_cv_tab();
    cv_tab_t tab;
    for (int m = 0; m < VALUE_MOD; m++) begin
      tab[m] = FRAC_BITS'(((longint'(m) << FRAC_BITS) + VALUE_MOD / 2) / VALUE_MOD);
    end
    return tab;
  endfunction

  localparam cv_tab_t CV_TAB = build_cv_tab();

  function automatic logic [MOD_Q_W-1:0] mod_quot(input logic [MOD_ARG_W-1:0] u);
    logic [2*MOD_ARG_W-1:0] prod;
    prod = {{MOD_ARG_W{1'b0}}, u} * {{MOD_ARG_W{1'b0}}, MOD_RECIP};
    return prod[2*MOD_ARG_W-1:MOD_SHIFT];
  endfunction

  function automatic res_t mod_fix(input logic [MOD_ARG_W-1:0] u,
                                   input logic [MOD_Q_W-1:0]   q);
    logic [MOD_ARG_W-1:0] r;
    r = u - MOD_ARG_W'({{(MOD_ARG_W-MOD_Q_W){1'b0}}, q} * MOD_ARG_W'(HASH_MOD));
    if (r >= MOD_ARG_W'(HASH_MOD)) begin
      r = r - MOD_ARG_W'(HASH_MOD);
    end
    return r[RES_W-1:0];
  endfunction

  function automatic res_t add_mod(input res_t a, input res_t b, input logic c);
    logic [RES_W:0] s;
    s = {1'b0, a} + {1'b0, b} + (RES_W+1)'(c);
    if (s >= (RES_W+1)'(HASH_MOD)) begin
      s = s - (RES_W+1)'(HASH_MOD);
    end
    return s[RES_W-1:0];
  endfunction

endpackage

FILE: rtl/fvn_stream_if.sv
// Valid/ready stream interfaces for the point requests and the noise results.
// Depends on fvn_pkg for field widths.

interface fvn_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [fvn_pkg::POS_W-1:0]        pos_x;
  logic signed [fvn_pkg::POS_W-1:0]        pos_y;
  logic signed [fvn_pkg::POS_W-1:0]        pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface fvn_out_if;
  logic                        valid;
  logic                        ready;
  logic [fvn_pkg::SUM_W-1:0]   noise_sum;

  modport source (output valid, noise_sum, input ready);
  modport sink   (input valid, noise_sum, output ready);
endinterface

FILE: rtl/fbm_value_noise_3d_unit.sv
// Fractal value noise unit: octave lanes in parallel, summed and saturated.
// Accepts one request per cycle unless a stalled result backs up the pipeline.
// The depth is set by the hash chain (three mod-289 permutations of three stages
// each) and three levels of two-stage blends; every stage stalls independently.
// Asynchronous active-low reset clears the valid bits and the two registers
// (octave_count 6, base_shift 3); datapath registers are not reset.

module fbm_value_noise_3d_unit #(
  parameter int MAX_OCTAVES = fvn_pkg::DEF_MAX_OCTAVES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fvn_in_if.sink      in_if,
  fvn_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N    = fvn_pkg::PIPE_STAGES;
  localparam int LS   = fvn_pkg::LANE_STAGES;
  localparam int SH_W = $clog2(fvn_pkg::SHIFT_LIMIT + MAX_OCTAVES);
  localparam int CNT_W = $clog2(MAX_OCTAVES + 1) + 1;
  localparam int ACC_W = fvn_pkg::SUM_W + $clog2(MAX_OCTAVES + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers (APB, zero-wait). Word index is paddr[2].
  // ---------------------------------------------------------------------------
  logic [fvn_pkg::CFG_W-1:0] octave_count_q, base_shift_q;
  logic                      wr_en;
  fvn_pkg::cfg_reg_e         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = fvn_pkg::cfg_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_count_q <= fvn_pkg::CFG_W'(6);
      base_shift_q   <= fvn_pkg::CFG_W'(3);
    end else if (wr_en) begin
      case (reg_sel)
        fvn_pkg::REG_OCTAVE_COUNT: octave_count_q <= pwdata[fvn_pkg::CFG_W-1:0];
        fvn_pkg::REG_BASE_SHIFT:   base_shift_q   <= pwdata[fvn_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      fvn_pkg::REG_OCTAVE_COUNT: prdata = 32'(octave_count_q);
      fvn_pkg::REG_BASE_SHIFT:   prdata = 32'(base_shift_q);
      default:                   prdata = '0;
    endcase
  end

  // Clamped settings: zero octaves acts as one, shift limited to SHIFT_LIMIT.
  logic [CNT_W-1:0] n_eff;
  logic [SH_W-1:0]  s_eff;

  always_comb begin
    if (octave_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(octave_count_q) > CNT_W'(MAX_OCTAVES)) begin
      n_eff = CNT_W'(MAX_OCTAVES);
    end else begin
      n_eff = CNT_W'(octave_count_q);
    end
    if (base_shift_q > fvn_pkg::CFG_W'(fvn_pkg::SHIFT_LIMIT)) begin
      s_eff = SH_W'(fvn_pkg::SHIFT_LIMIT);
    end else begin
      s_eff = SH_W'(base_shift_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage loads when empty or when the next one moves,
  // so bubbles collapse and the input keeps flowing behind a stalled result.
  // ---------------------------------------------------------------------------
  logic [N:1]   v_q;
  logic [N+1:1] en;

  always_comb begin
    en[N+1] = out_if.ready;
    for (int k = N; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_if.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_if.valid;
      for (int k = 2; k <= N; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Octave lanes: lane i works at scale 2^(base_shift+i).
  // ---------------------------------------------------------------------------
  fvn_pkg::val_t term [MAX_OCTAVES];

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
    fvn_lane #(
      .MAX_OCTAVES(MAX_OCTAVES),
      .LANE       (i)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en[LS:1]),
      .shift_i(s_eff + SH_W'(i)),
      .pos_x_i(in_if.pos_x),
      .pos_y_i(in_if.pos_y),
      .pos_z_i(in_if.pos_z),
      .term_o (term[i])
    );
  end

  // Final stage: sum of enabled octaves, saturated, held in the output register.
  logic [ACC_W-1:0]          acc;
  logic [fvn_pkg::SUM_W-1:0] sum_d, sum_q;

  always_comb begin
    acc = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      if (CNT_W'(i) < n_eff) begin
        acc = acc + ACC_W'(term[i]);
      end
    end
    if (acc > ACC_W'({fvn_pkg::SUM_W{1'b1}})) begin
      sum_d = '1;
    end else begin
      sum_d = acc[fvn_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[N]) begin
      sum_q <= sum_d;
    end
  end

  assign out_if.valid     = v_q[N];
  assign out_if.noise_sum = sum_q;

endmodule

FILE: rtl/fvn_perm.sv
// Three-stage permutation hash ((34r+1)r) mod 289 on a residue.
// Depends on fvn_pkg.

module fvn_perm (
  input  logic          clk_i,
  input  logic [2:0]    en_i,
  input  fvn_pkg::res_t r_i,
  output fvn_pkg::res_t h_o
);

  logic [fvn_pkg::MOD_ARG_W-1:0] m_d, m_q, u_q;
  logic [fvn_pkg::MOD_Q_W-1:0]   q_q;
  fvn_pkg::res_t                 h_q;

  always_comb begin
    logic [fvn_pkg::MOD_ARG_W-1:0] a;
    a   = fvn_pkg::MOD_ARG_W'(r_i) * fvn_pkg::MOD_ARG_W'(fvn_pkg::HASH_MUL) + 1'b1;
    m_d = a * fvn_pkg::MOD_ARG_W'(r_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      m_q <= m_d;
    end
    if (en_i[1]) begin
      u_q <= m_q;
      q_q <= fvn_pkg::mod_quot(m_q);
    end
    if (en_i[2]) begin
      h_q <= fvn_pkg::mod_fix(u_q, q_q);
    end
  end

  assign h_o = h_q;

endmodule

FILE: rtl/fvn_lerp.sv
// Two-stage fixed-point linear blend lo*(1-w) + hi*w, rounded half up.
// Depends on fvn_pkg.

module fvn_lerp (
  input  logic          clk_i,
  input  logic [1:0]    en_i,
  input  fvn_pkg::val_t lo_i,
  input  fvn_pkg::val_t hi_i,
  input  fvn_pkg::val_t w_i,
  output fvn_pkg::val_t y_o
);

  localparam int PW = 2 * fvn_pkg::VAL_W;

  logic [PW-1:0]     a_q, b_q;
  logic [PW:0]       s;
  fvn_pkg::val_t     y_q;
  fvn_pkg::val_t     wc;

  assign wc = fvn_pkg::val_t'(1 << fvn_pkg::FRAC_BITS) - w_i;
  assign s  = {1'b0, a_q} + {1'b0, b_q} + (PW+1)'(1 << (fvn_pkg::FRAC_BITS - 1));

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q <= PW'(lo_i) * PW'(wc);
      b_q <= PW'(hi_i) * PW'(w_i);
    end
    if (en_i[1]) begin
      y_q <= s[fvn_pkg::FRAC_BITS +: fvn_pkg::VAL_W];
    end
  end

  assign y_o = y_q;

endmodule

FILE: rtl/fvn_lane.sv
// One octave of value noise: split, lattice hashing, smoothstep and trilinear blend,
// weighted by the octave amplitude. Depends on fvn_pkg, fvn_perm and fvn_lerp.

module fvn_lane #(
  parameter int MAX_OCTAVES = fvn_pkg::DEF_MAX_OCTAVES,
  parameter int LANE        = 0
) (
  input  logic                                  clk_i,
  input  logic [fvn_pkg::LANE_STAGES:1]         en_i,
  input  logic [$clog2(fvn_pkg::SHIFT_LIMIT+MAX_OCTAVES)-1:0] shift_i,
  input  logic signed [fvn_pkg::POS_W-1:0]      pos_x_i,
  input  logic signed [fvn_pkg::POS_W-1:0]      pos_y_i,
  input  logic signed [fvn_pkg::POS_W-1:0]      pos_z_i,
  output fvn_pkg::val_t                         term_o
);

  localparam int FB   = fvn_pkg::FRAC_BITS;
  localparam int KMAX = fvn_pkg::SHIFT_LIMIT + MAX_OCTAVES - 1;
  localparam int PW   = fvn_pkg::POS_W + KMAX;
  localparam int CW   = PW - FB;
  localparam int CELL_BIAS =
    fvn_pkg::HASH_MOD * ((2 ** (CW - 1) + fvn_pkg::HASH_MOD - 1) / fvn_pkg::HASH_MOD);
  localparam int AW   = fvn_pkg::MOD_ARG_W;
  localparam int TW   = FB + 2;
  localparam int WMW  = fvn_pkg::VAL_W + TW;
  localparam int TPW  = fvn_pkg::VAL_W + fvn_pkg::AMP_W;

  logic signed [fvn_pkg::POS_W-1:0] pos [3];
  logic signed [PW-1:0]             ps  [3];

  // stage 1..3: lattice cell, fraction, residues and weight terms
  logic signed [CW-1:0]       cell_q [3];
  logic [FB-1:0]              frac_q [3];
  logic [AW-1:0]              u_q    [3];
  logic [fvn_pkg::MOD_Q_W-1:0] q_q   [3];
  logic [2*FB-1:0]            dd_q   [3];
  logic [FB-1:0]              d_q    [3];
  fvn_pkg::res_t              r_q    [3];
  fvn_pkg::val_t              d2_q   [3];
  logic [TW-1:0]              t_q    [3];
  logic [WMW-1:0]             wm_q   [3];

  fvn_pkg::res_t ryd [4:6];
  fvn_pkg::res_t rzd [4:9];
  fvn_pkg::val_t wxd [5:16];
  fvn_pkg::val_t wyd [5:18];
  fvn_pkg::val_t wzd [5:14];

  fvn_pkg::res_t hx   [2];
  fvn_pkg::res_t rx1;
  fvn_pkg::res_t p2   [4];
  fvn_pkg::res_t h3   [8];

  fvn_pkg::res_t                ch_q [8];
  logic [fvn_pkg::V41_P_W-1:0]  cp   [8];
  logic [fvn_pkg::V41_P_W-fvn_pkg::V41_SHIFT-1:0] cq_q [8];
  logic [FB-1:0]                cv_q [8];

  fvn_pkg::val_t ez [4];
  fvn_pkg::val_t ex [2];
  fvn_pkg::val_t nv;

  logic [TPW-1:0]  tp_q;
  logic [TPW:0]    tp_r;
  fvn_pkg::val_t   term_q;

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ps[a] = PW'(pos[a]) <<< shift_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      if (en_i[1]) begin
        cell_q[a] <= ps[a][PW-1:FB];
        frac_q[a] <= ps[a][FB-1:0];
      end
      if (en_i[2]) begin
        logic signed [AW-1:0] cs;
        cs = AW'(cell_q[a]);
        u_q[a]  <= AW'(cs + AW'(CELL_BIAS));
        q_q[a]  <= fvn_pkg::mod_quot(AW'(cs + AW'(CELL_BIAS)));
        dd_q[a] <= (2*FB)'(frac_q[a]) * (2*FB)'(frac_q[a]);
        d_q[a]  <= frac_q[a];
      end
      if (en_i[3]) begin
        logic [2*FB:0] dr;
        dr = {1'b0, dd_q[a]} + (2*FB+1)'(1 << (FB - 1));
        r_q[a]  <= fvn_pkg::mod_fix(u_q[a], q_q[a]);
        d2_q[a] <= dr[FB +: fvn_pkg::VAL_W];
        t_q[a]  <= TW'(3 << FB) - {1'b0, d_q[a], 1'b0};
      end
      if (en_i[4]) begin
        wm_q[a] <= WMW'(d2_q[a]) * WMW'(t_q[a]);
      end
    end
  end

  // residue and weight delay lines, each tap read at one fixed stage
  always_ff @(posedge clk_i) begin
    logic [WMW:0] wr [3];
    for (int a = 0; a < 3; a++) begin
      wr[a] = {1'b0, wm_q[a]} + (WMW+1)'(1 << (FB - 1));
    end
    if (en_i[4]) begin
      ryd[4] <= r_q[1];
      rzd[4] <= r_q[2];
    end
    for (int k = 5; k <= 6; k++) begin
      if (en_i[k]) ryd[k] <= ryd[k-1];
    end
    for (int k = 5; k <= 9; k++) begin
      if (en_i[k]) rzd[k] <= rzd[k-1];
    end
    if (en_i[5]) begin
      wxd[5] <= wr[0][FB +: fvn_pkg::VAL_W];
      wyd[5] <= wr[1][FB +: fvn_pkg::VAL_W];
      wzd[5] <= wr[2][FB +: fvn_pkg::VAL_W];
    end
    for (int k = 6; k <= 16; k++) begin
      if (en_i[k]) wxd[k] <= wxd[k-1];
    end
    for (int k = 6; k <= 18; k++) begin
      if (en_i[k]) wyd[k] <= wyd[k-1];
    end
    for (int k = 6; k <= 14; k++) begin
      if (en_i[k]) wzd[k] <= wzd[k-1];
    end
  end

  // x lattice hashes, stages 4..6
  assign rx1 = (r_q[0] == fvn_pkg::res_t'(fvn_pkg::HASH_MOD - 1)) ? '0 : r_q[0] + 1'b1;

  fvn_perm u_px0 (.clk_i(clk_i), .en_i(en_i[6:4]), .r_i(r_q[0]), .h_o(hx[0]));
  fvn_perm u_px1 (.clk_i(clk_i), .en_i(en_i[6:4]), .r_i(rx1),    .h_o(hx[1]));

  // y level, stages 7..9: order 00, 10, 01, 11
  for (genvar j = 0; j < 4; j++) begin : g_lvl2
    fvn_perm u_p (
      .clk_i(clk_i),
      .en_i (en_i[9:7]),
      .r_i  (fvn_pkg::add_mod(hx[j % 2], ryd[6], 1'(j / 2))),
      .h_o  (p2[j])
    );
  end

  // z level, stages 10..12: low and high corner per pair
  for (genvar c = 0; c < 8; c++) begin : g_lvl3
    fvn_perm u_p (
      .clk_i(clk_i),
      .en_i (en_i[12:10]),
      .r_i  (fvn_pkg::add_mod(p2[c / 2], rzd[9], 1'(c % 2))),
      .h_o  (h3[c])
    );
  end

  // corner values, stages 13..14
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      cp[c] = fvn_pkg::V41_P_W'(h3[c]) * fvn_pkg::V41_P_W'(fvn_pkg::V41_RECIP);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 8; c++) begin
      if (en_i[13]) begin
        ch_q[c] <= h3[c];
        cq_q[c] <= cp[c][fvn_pkg::V41_P_W-1:fvn_pkg::V41_SHIFT];
      end
      if (en_i[14]) begin
        fvn_pkg::res_t m;
        m = ch_q[c] - fvn_pkg::res_t'(cq_q[c] * fvn_pkg::RES_W'(fvn_pkg::VALUE_MOD));
        cv_q[c] <= fvn_pkg::CV_TAB[m[fvn_pkg::VM_W-1:0]];
      end
    end
  end

  // trilinear blend: z at 15..16, x at 17..18, y at 19..20
  for (genvar j = 0; j < 4; j++) begin : g_lz
    fvn_lerp u_l (
      .clk_i(clk_i), .en_i(en_i[16:15]),
      .lo_i (fvn_pkg::val_t'(cv_q[2*j])), .hi_i(fvn_pkg::val_t'(cv_q[2*j+1])),
      .w_i  (wzd[14]), .y_o(ez[j])
    );
  end

  for (genvar k = 0; k < 2; k++) begin : g_lx
    fvn_lerp u_l (
      .clk_i(clk_i), .en_i(en_i[18:17]),
      .lo_i (ez[2*k]), .hi_i(ez[2*k+1]), .w_i(wxd[16]), .y_o(ex[k])
    );
  end

  fvn_lerp u_ly (
    .clk_i(clk_i), .en_i(en_i[20:19]),
    .lo_i (ex[0]), .hi_i(ex[1]), .w_i(wyd[18]), .y_o(nv)
  );

  // amplitude weighting, stages 21..22
  assign tp_r = {1'b0, tp_q} + (TPW+1)'(1 << (fvn_pkg::AMP_SHIFT - 1));

  always_ff @(posedge clk_i) begin
    if (en_i[21]) begin
      tp_q <= TPW'(nv) * TPW'(fvn_pkg::AMP_Q16[LANE]);
    end
    if (en_i[22]) begin
      term_q <= tp_r[fvn_pkg::AMP_SHIFT +: fvn_pkg::VAL_W];
    end
  end

  assign term_o = term_q;

endmodule
